>>> src/gdd_pkg.sv
`timescale 1ns / 1ps

package gdd_pkg;

   // Field widths of the two dates and of the result.
   localparam int YEAR_W  = 12;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int DIFF_W  = 21;

   // A day count lies between -32 and about 1.5 million, so 22 signed bits hold it.
   localparam int COUNT_W = 22;
   // The difference of two counts gets one more bit before it is saturated.
   localparam int WIDE_W  = COUNT_W + 1;

   // Century years from 1700 to 3900 that are not divisible by 400.
   localparam int NUM_CENTURIES = 18;
   localparam int SKIP_W        = 5;
   localparam int GROUP_SIZE    = 6;
   localparam int NUM_GROUPS    = NUM_CENTURIES / GROUP_SIZE;

   localparam logic [YEAR_W-1:0] CENTURY_YEARS [NUM_CENTURIES] = '{
      12'd1700, 12'd1800, 12'd1900, 12'd2100, 12'd2200, 12'd2300,
      12'd2500, 12'd2600, 12'd2700, 12'd2900, 12'd3000, 12'd3100,
      12'd3300, 12'd3400, 12'd3500, 12'd3700, 12'd3800, 12'd3900
   };

   // Month codes that matter to the formula.
   localparam logic [MONTH_W-1:0] MONTH_FEBRUARY = 4'd2;
   // Last day of February that counts as the skipped leap day.
   localparam logic [DAY_W-1:0]   LEAP_DAY       = 5'd29;

   // Saturation bounds of the result.
   localparam logic signed [WIDE_W-1:0] DIFF_MAX = WIDE_W'(signed'(1048575));
   localparam logic signed [WIDE_W-1:0] DIFF_MIN = -WIDE_W'(signed'(1048576));

   typedef logic signed [COUNT_W-1:0] count_type;
   typedef logic signed [WIDE_W-1:0]  wide_type;

   // Offset subtracted after February: floor(0.4 * month + 2.3), zero before March.
   function automatic logic [3:0] month_offset(input logic [MONTH_W-1:0] month);
      logic [3:0] offset;
      unique case (month)
         4'd0, 4'd1, 4'd2:     offset = 4'd0;
         4'd3, 4'd4:           offset = 4'd3;
         4'd5, 4'd6:           offset = 4'd4;
         4'd7, 4'd8, 4'd9:     offset = 4'd5;
         4'd10, 4'd11:         offset = 4'd6;
         4'd12, 4'd13, 4'd14:  offset = 4'd7;
         4'd15:                offset = 4'd8;
      endcase
      return offset;
   endfunction

endpackage

>>> src/gregorian_day_difference.sv
`timescale 1ns / 1ps

// Signed number of days between two Gregorian dates.
//
// Input channel: drive the six req_ date fields and raise start. A transfer
// takes place at every rising edge with start high and busy low. busy is
// always low, so a new pair of dates can be taken in every cycle.
// Result channel: rsp_strobe is high for exactly one cycle with the day
// difference (newer minus older) on rsp_day_difference. The transfer ends
// at the edge that closes that cycle; the receiver cannot hold it off.
// Pipeline: the dates go into an input register at the accepting edge and
// the result register loads at the next edge, which raises the strobe.
// Throughput is one item per cycle, set by the single stage of day-count
// logic between the two registers.
// A difference beyond the 21-bit signed range saturates.
// Reset (synchronous, active high) clears both valid flags; no result is
// lost to a stall since the receiver takes every result as it appears.

module gregorian_day_difference (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [gdd_pkg::YEAR_W-1:0]         req_old_year,
   input  logic [gdd_pkg::MONTH_W-1:0]        req_old_month,
   input  logic [gdd_pkg::DAY_W-1:0]          req_old_day,
   input  logic [gdd_pkg::YEAR_W-1:0]         req_new_year,
   input  logic [gdd_pkg::MONTH_W-1:0]        req_new_month,
   input  logic [gdd_pkg::DAY_W-1:0]          req_new_day,
   output logic                               rsp_strobe,
   output logic signed [gdd_pkg::DIFF_W-1:0]  rsp_day_difference
);

   logic                               accept;
   logic                               stage_valid_ff;
   logic [gdd_pkg::YEAR_W-1:0]         old_year_ff;
   logic [gdd_pkg::MONTH_W-1:0]        old_month_ff;
   logic [gdd_pkg::DAY_W-1:0]          old_day_ff;
   logic [gdd_pkg::YEAR_W-1:0]         new_year_ff;
   logic [gdd_pkg::MONTH_W-1:0]        new_month_ff;
   logic [gdd_pkg::DAY_W-1:0]          new_day_ff;
   gdd_pkg::count_type                 old_count;
   gdd_pkg::count_type                 new_count;
   gdd_pkg::wide_type                  wide_diff;
   logic signed [gdd_pkg::DIFF_W-1:0]  diff_in;
   logic                               rsp_valid_ff;
   logic signed [gdd_pkg::DIFF_W-1:0]  rsp_day_difference_ff;

   // The pipeline never stalls, so the block is never busy.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= accept;
      end
      if (accept) begin
         old_year_ff  <= req_old_year;
         old_month_ff <= req_old_month;
         old_day_ff   <= req_old_day;
         new_year_ff  <= req_new_year;
         new_month_ff <= req_new_month;
         new_day_ff   <= req_new_day;
      end
   end

   // Day counts of both dates.
   gdd_day_count u_old_count (
      .year  (old_year_ff),
      .month (old_month_ff),
      .day   (old_day_ff),
      .count (old_count)
   );

   gdd_day_count u_new_count (
      .year  (new_year_ff),
      .month (new_month_ff),
      .day   (new_day_ff),
      .count (new_count)
   );

   // Difference with saturation to the result width.
   assign wide_diff = gdd_pkg::wide_type'(new_count) - gdd_pkg::wide_type'(old_count);

   always_comb begin
      priority if (wide_diff > gdd_pkg::DIFF_MAX) begin
         diff_in = gdd_pkg::DIFF_MAX[gdd_pkg::DIFF_W-1:0];
      end else if (wide_diff < gdd_pkg::DIFF_MIN) begin
         diff_in = gdd_pkg::DIFF_MIN[gdd_pkg::DIFF_W-1:0];
      end else begin
         diff_in = wide_diff[gdd_pkg::DIFF_W-1:0];
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= stage_valid_ff;
      end
      rsp_day_difference_ff <= diff_in;
   end

   assign rsp_strobe         = rsp_valid_ff;
   assign rsp_day_difference = rsp_day_difference_ff;

   // Every accepted transfer gives a result through the input and result registers.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_strobe)
      else $error("accepted dates produced no result");

   // No result appears without a transfer that passed the input and result registers.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, 2))
      else $error("result strobe without an accepted transfer");

   // Two equal dates are zero days apart.
   assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && (old_year_ff == new_year_ff) && (old_month_ff == new_month_ff)
       && (old_day_ff == new_day_ff)) |=> (rsp_day_difference == '0))
      else $error("equal dates gave a nonzero difference");

endmodule

>>> src/gdd_day_count.sv
`timescale 1ns / 1ps

module gdd_day_count (
   input  logic [gdd_pkg::YEAR_W-1:0]  year,
   input  logic [gdd_pkg::MONTH_W-1:0] month,
   input  logic [gdd_pkg::DAY_W-1:0]   day,
   output gdd_pkg::count_type          count
);

   logic                            early_month;
   logic [gdd_pkg::YEAR_W-1:0]      z_year;
   logic [gdd_pkg::YEAR_W-3:0]      quarter;
   gdd_pkg::count_type              year_term;
   gdd_pkg::count_type              month_term;
   gdd_pkg::count_type              quarter_term;
   logic                            past_leap_day;
   logic [gdd_pkg::NUM_CENTURIES-1:0] reached;
   logic [2:0]                      group_sum [gdd_pkg::NUM_GROUPS];
   logic [gdd_pkg::SKIP_W-1:0]      skips;

   // January and February take the leap term from the previous year.
   assign early_month = (month <= gdd_pkg::MONTH_FEBRUARY);
   assign z_year      = early_month ? (year - gdd_pkg::YEAR_W'(1)) : year;
   assign quarter     = z_year[gdd_pkg::YEAR_W-1:2];

   // Year and month terms; month zero gives minus 31.
   assign year_term  = gdd_pkg::count_type'({10'd0, year}) * gdd_pkg::count_type'(365);
   assign month_term = gdd_pkg::count_type'({18'd0, month}) * gdd_pkg::count_type'(31)
                       - gdd_pkg::count_type'(31);

   // Year zero before March floors to minus one.
   assign quarter_term = (early_month && (year == '0)) ? gdd_pkg::count_type'(-1)
                         : gdd_pkg::count_type'({12'd0, quarter});

   // The date is at or past February 29 of its own year.
   assign past_leap_day = (month > gdd_pkg::MONTH_FEBRUARY) ||
                          ((month == gdd_pkg::MONTH_FEBRUARY) && (day >= gdd_pkg::LEAP_DAY));

   // One compare against each skipped century leap day.
   always_comb begin
      for (int i = 0; i < gdd_pkg::NUM_CENTURIES; i++) begin
         reached[i] = ({year, past_leap_day} >= {gdd_pkg::CENTURY_YEARS[i], 1'b1});
      end
   end

   // Count the reached centuries in small groups, then add the groups.
   always_comb begin
      for (int g = 0; g < gdd_pkg::NUM_GROUPS; g++) begin
         group_sum[g] = '0;
         for (int i = 0; i < gdd_pkg::GROUP_SIZE; i++) begin
            group_sum[g] = group_sum[g] + 3'(reached[g*gdd_pkg::GROUP_SIZE + i]);
         end
      end
      skips = '0;
      for (int g = 0; g < gdd_pkg::NUM_GROUPS; g++) begin
         skips = skips + gdd_pkg::SKIP_W'(group_sum[g]);
      end
   end

   assign count = year_term + month_term
                  + gdd_pkg::count_type'({17'd0, day})
                  + quarter_term
                  - gdd_pkg::count_type'({18'd0, gdd_pkg::month_offset(month)})
                  - gdd_pkg::count_type'({17'd0, skips});

endmodule
